// File: rtl/core/pip_pkg.sv
// Shared types and constants of the package index parser.
`default_nettype none
package pip_pkg;

   localparam int unsigned MAX_FILES_DEFAULT   = 1024;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned CSR_ADDR_W          = 3;
   localparam int unsigned CSR_DATA_W          = 32;

   typedef enum logic [1:0] {
      REC_CHAR   = 2'd0,
      REC_HEADER = 2'd1,
      REC_ENTRY  = 2'd2,
      REC_STATUS = 2'd3
   } pip_rec_type;

   typedef enum logic [1:0] {
      FIELD_NAME    = 2'd0,
      FIELD_VERSION = 2'd1,
      FIELD_ARCH    = 2'd2,
      FIELD_PATH    = 2'd3
   } pip_field_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_BAD_MAGIC = 3'd2,
      ST_TOO_MANY  = 3'd3,
      ST_OVERRUN   = 3'd4,
      ST_RANGE_OUT = 3'd5,
      ST_OVERFLOW  = 3'd6
   } pip_status_type;

   typedef struct packed {
      logic [31:0] magic_value;
      logic [10:0] max_entries;
   } pip_cfg_type;

   // One command per item that has results: a first record, and optionally
   // a trailing status record.
   typedef struct packed {
      pip_rec_type    rec;
      pip_field_type  field;
      logic [7:0]     char_value;
      logic [9:0]     entry_index;
      logic [63:0]    file_offset;
      logic [63:0]    file_size;
      logic [63:0]    file_hash;
      pip_status_type status;
      logic [31:0]    file_count;
      logic           tail;
      pip_status_type tail_status;
      logic [31:0]    tail_count;
   } pip_cmd_type;

   typedef struct packed {
      pip_rec_type    rec;
      pip_field_type  field;
      logic [7:0]     char_value;
      logic [9:0]     entry_index;
      logic [63:0]    file_offset;
      logic [63:0]    file_size;
      logic [63:0]    file_hash;
      pip_status_type status;
      logic [31:0]    file_count;
      logic           last;
   } pip_rsp_type;

endpackage
`default_nettype wire

// File: rtl/core/pip_csr.sv
// Configuration registers of the package index parser.
`default_nettype none
module pip_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pip_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [pip_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [pip_pkg::CSR_DATA_W-1:0]      prdata,
   output pip_pkg::pip_cfg_type                cfg
);

   localparam logic REG_MAGIC = 1'b0;
   localparam logic REG_MAX   = 1'b1;

   logic [31:0] magic_ff, magic_in;
   logic [10:0] max_ff, max_in;
   logic        wr_en;

   assign wr_en = psel & penable & pwrite;

   always_comb begin
      magic_in = magic_ff;
      max_in   = max_ff;
      prdata   = '0;
      unique case (paddr[2])
         REG_MAGIC: begin
            prdata = magic_ff;
            if (wr_en) magic_in = pwdata;
         end
         REG_MAX: begin
            prdata = {21'd0, max_ff};
            if (wr_en) max_in = pwdata[10:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0;
         max_ff   <= 11'd1024;
      end else begin
         magic_ff <= magic_in;
         max_ff   <= max_in;
      end
   end

   assign cfg.magic_value = magic_ff;
   assign cfg.max_entries = max_ff;

endmodule
`default_nettype wire

// File: rtl/core/pip_front.sv
// Front end: parses package bytes and emits result commands.
`default_nettype none
module pip_front #(
   parameter int unsigned MAX_FILES = pip_pkg::MAX_FILES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 kind,
   input  logic [7:0]           data_byte,
   input  logic [63:0]          package_length,
   input  pip_pkg::pip_cfg_type cfg,
   output logic                 push,
   output pip_pkg::pip_cmd_type cmd
);

   localparam int unsigned NF_W   = $clog2(MAX_FILES + 1);
   localparam int unsigned NEED_W = NF_W + 8;

   localparam logic KIND_BEGIN = 1'b0;

   localparam logic [6:0] MAGIC_LAST   = 7'd3;
   localparam logic [6:0] NAME_FIRST   = 7'd4;
   localparam logic [6:0] NAME_LAST    = 7'd35;
   localparam logic [6:0] VERSION_LAST = 7'd51;
   localparam logic [6:0] ARCH_LAST    = 7'd59;
   localparam logic [6:0] HEADER_LAST  = 7'd63;
   localparam logic [6:0] PATH_LAST    = 7'd63;
   localparam logic [6:0] OFFSET_LAST  = 7'd71;
   localparam logic [6:0] SIZE_LAST    = 7'd79;
   localparam logic [6:0] ENTRY_LAST   = 7'd87;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_ENTRIES = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [6:0]  pos_ff, pos_in;
   logic [10:0] entry_num_ff, entry_num_in;
   logic [10:0] limit_ff, limit_in;
   logic [31:0] declared_ff, declared_in;
   logic [31:0] word_ff, word_in;
   logic [63:0] total_ff, total_in;
   logic [63:0] off_ff, off_in;
   logic [63:0] size_ff, size_in;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] sum_ff, sum_in;
   logic        carry_ff, carry_in;

   logic [31:0]       word_new;
   logic [63:0]       hash_new;
   logic [NEED_W-1:0] need;
   logic [31:0]       max_wide;
   logic [11:0]       next_num;

   assign word_new = {data_byte, word_ff[31:8]};
   assign hash_new = {data_byte, hash_ff[63:8]};
   assign need     = NEED_W'(64) + NEED_W'(word_new[NF_W-1:0]) * NEED_W'(88);
   assign max_wide = {21'd0, cfg.max_entries};
   assign next_num = {1'b0, entry_num_ff} + 12'd1;
   // offset + size, settled well before the last hash byte
   assign {carry_in, sum_in} = {1'b0, off_ff} + {1'b0, size_ff};

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      entry_num_in = entry_num_ff;
      limit_in     = limit_ff;
      declared_in  = declared_ff;
      word_in      = word_ff;
      total_in     = total_ff;
      off_in       = off_ff;
      size_in      = size_ff;
      hash_in      = hash_ff;
      push         = 1'b0;
      cmd          = '0;
      if (accept) begin
         if (kind == KIND_BEGIN) begin
            total_in     = package_length;
            pos_in       = '0;
            entry_num_in = '0;
            limit_in     = '0;
            declared_in  = '0;
            if (package_length < 64'd64) begin
               push       = 1'b1;
               cmd.rec    = pip_pkg::REC_STATUS;
               cmd.status = pip_pkg::ST_SHORT;
               phase_in   = PH_IDLE;
            end else begin
               phase_in = PH_HEADER;
            end
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  word_in = word_new;
                  pos_in  = pos_ff + 7'd1;
                  if (pos_ff == MAGIC_LAST) begin
                     if (word_new != cfg.magic_value) begin
                        push       = 1'b1;
                        cmd.rec    = pip_pkg::REC_STATUS;
                        cmd.status = pip_pkg::ST_BAD_MAGIC;
                        phase_in   = PH_IDLE;
                     end
                  end else if (pos_ff >= NAME_FIRST && pos_ff <= ARCH_LAST) begin
                     push    = 1'b1;
                     cmd.rec = pip_pkg::REC_CHAR;
                     if (pos_ff <= NAME_LAST) begin
                        cmd.field      = pip_pkg::FIELD_NAME;
                        cmd.char_value = (pos_ff == NAME_LAST) ? 8'd0 : data_byte;
                     end else if (pos_ff <= VERSION_LAST) begin
                        cmd.field      = pip_pkg::FIELD_VERSION;
                        cmd.char_value = (pos_ff == VERSION_LAST) ? 8'd0 : data_byte;
                     end else begin
                        cmd.field      = pip_pkg::FIELD_ARCH;
                        cmd.char_value = (pos_ff == ARCH_LAST) ? 8'd0 : data_byte;
                     end
                  end else if (pos_ff == HEADER_LAST) begin
                     declared_in = word_new;
                     push        = 1'b1;
                     phase_in    = PH_IDLE;
                     if (word_new > 32'(MAX_FILES)) begin
                        cmd.rec    = pip_pkg::REC_STATUS;
                        cmd.status = pip_pkg::ST_TOO_MANY;
                     end else if (64'(need) > total_ff) begin
                        cmd.rec    = pip_pkg::REC_STATUS;
                        cmd.status = pip_pkg::ST_OVERRUN;
                     end else begin
                        cmd.rec        = pip_pkg::REC_HEADER;
                        cmd.file_count = word_new;
                        if (cfg.max_entries == 11'd0) begin
                           cmd.tail        = 1'b1;
                           cmd.tail_status = pip_pkg::ST_OK;
                           cmd.tail_count  = word_new;
                        end else if (word_new == 32'd0) begin
                           cmd.tail        = 1'b1;
                           cmd.tail_status = pip_pkg::ST_OK;
                           cmd.tail_count  = '0;
                        end else begin
                           phase_in     = PH_ENTRIES;
                           entry_num_in = '0;
                           pos_in       = '0;
                           limit_in     = (word_new < max_wide) ? word_new[10:0]
                                                                : cfg.max_entries;
                        end
                     end
                  end
               end
               PH_ENTRIES: begin
                  pos_in = pos_ff + 7'd1;
                  if (pos_ff <= PATH_LAST) begin
                     push            = 1'b1;
                     cmd.rec         = pip_pkg::REC_CHAR;
                     cmd.field       = pip_pkg::FIELD_PATH;
                     cmd.entry_index = entry_num_ff[9:0];
                     cmd.char_value  = (pos_ff == PATH_LAST) ? 8'd0 : data_byte;
                  end else if (pos_ff <= OFFSET_LAST) begin
                     off_in = {data_byte, off_ff[63:8]};
                  end else if (pos_ff <= SIZE_LAST) begin
                     size_in = {data_byte, size_ff[63:8]};
                  end else begin
                     hash_in = hash_new;
                  end
                  if (pos_ff == ENTRY_LAST) begin
                     push            = 1'b1;
                     cmd.rec         = pip_pkg::REC_ENTRY;
                     cmd.entry_index = entry_num_ff[9:0];
                     cmd.file_offset = off_ff;
                     cmd.file_size   = size_ff;
                     cmd.file_hash   = hash_new;
                     if (carry_ff || sum_ff > total_ff) begin
                        cmd.tail        = 1'b1;
                        cmd.tail_status = pip_pkg::ST_RANGE_OUT;
                        cmd.tail_count  = {20'd0, next_num};
                        phase_in        = PH_IDLE;
                     end else if (next_num >= {1'b0, limit_ff}) begin
                        cmd.tail        = 1'b1;
                        cmd.tail_status = (max_wide < declared_ff) ? pip_pkg::ST_OVERFLOW
                                                                   : pip_pkg::ST_OK;
                        cmd.tail_count  = {21'd0, limit_ff};
                        phase_in        = PH_IDLE;
                     end else begin
                        entry_num_in = next_num[10:0];
                        pos_in       = '0;
                     end
                  end
               end
               PH_IDLE: begin
                  pos_in = pos_ff;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         entry_num_ff <= '0;
         limit_ff     <= '0;
         declared_ff  <= '0;
         total_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         entry_num_ff <= entry_num_in;
         limit_ff     <= limit_in;
         declared_ff  <= declared_in;
         total_ff     <= total_in;
      end
      word_ff  <= word_in;
      off_ff   <= off_in;
      size_ff  <= size_in;
      hash_ff  <= hash_in;
      sum_ff   <= sum_in;
      carry_ff <= carry_in;
   end

endmodule
`default_nettype wire

// File: rtl/core/pip_queue.sv
// Short command queue between the parser front end and the result back end.
`default_nettype none
module pip_queue #(
   parameter int unsigned DEPTH = pip_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pip_pkg::pip_cmd_type push_cmd,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output pip_pkg::pip_cmd_type head_cmd
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   pip_pkg::pip_cmd_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slots_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) slots_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule
`default_nettype wire

// File: rtl/core/pip_back.sv
// Back end: expands commands into result items behind an output register.
`default_nettype none
module pip_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  pip_pkg::pip_cmd_type head_cmd,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pip_pkg::pip_rsp_type out_rsp
);

   logic                    out_valid_ff, out_valid_in;
   pip_pkg::pip_rsp_type    out_ff, out_in;
   logic                    pend_ff, pend_in;
   pip_pkg::pip_status_type pend_status_ff, pend_status_in;
   logic [31:0]             pend_count_ff, pend_count_in;
   logic                    load;

   assign load = ~out_valid_ff | out_ready;
   assign pop  = load & ~pend_ff & head_valid;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      pend_in        = pend_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      if (load) begin
         if (pend_ff) begin
            out_in            = '0;
            out_in.rec        = pip_pkg::REC_STATUS;
            out_in.status     = pend_status_ff;
            out_in.file_count = pend_count_ff;
            out_in.last       = 1'b1;
            out_valid_in      = 1'b1;
            pend_in           = 1'b0;
         end else if (head_valid) begin
            out_in.rec         = head_cmd.rec;
            out_in.field       = head_cmd.field;
            out_in.char_value  = head_cmd.char_value;
            out_in.entry_index = head_cmd.entry_index;
            out_in.file_offset = head_cmd.file_offset;
            out_in.file_size   = head_cmd.file_size;
            out_in.file_hash   = head_cmd.file_hash;
            out_in.status      = head_cmd.status;
            out_in.file_count  = head_cmd.file_count;
            out_in.last        = ~head_cmd.tail;
            out_valid_in       = 1'b1;
            pend_in            = head_cmd.tail;
            pend_status_in     = head_cmd.tail_status;
            pend_count_in      = head_cmd.tail_count;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
      out_ff         <= out_in;
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_ff;

endmodule
`default_nettype wire

// File: rtl/core/package_index_parser.sv
// Top level of the package index parser: stream ports, registers, front, queue, back.
`default_nettype none
// The parser takes one item per clock while the queue has room: a begin item
// (tuser 0) that carries the package length, then the package bytes (tuser 1) in
// order. The header's string bytes, the header count, each file entry's path bytes
// and record, and a final status come out as result items; an item gives at most
// two results, and the last one it gives carries tlast. The front end decodes each
// accepted item in the cycle it is accepted and writes at most one command into a
// short queue; the back end turns each command into one or two results through an
// output register, one result per cycle while rsp_tready is high. So req_tready
// stays high at one item per cycle as long as the queue has room, and an item whose
// work yields two results (header count plus status, or entry plus status) sends
// them out one after the other. A result passes through the queue and then the
// output register. Stalls on rsp_tready fill the queue (QUEUE_DEPTH commands)
// before req_tready drops. A begin item restarts the parse at any time; bytes that
// arrive before a begin or after a final status are dropped. Offset plus size of
// an entry is summed during the hash bytes and compared on the last one. Write
// magic_value (address 0) and max_entries (address 4) only while no item is in flight.
module package_index_parser #(
   parameter int unsigned MAX_FILES   = pip_pkg::MAX_FILES_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = pip_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // input item stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [71:0]                       req_tdata,   // data_byte[7:0], package_length[71:8]
   input  logic                              req_tuser,   // kind
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // char_value[7:0], entry_index[17:8], file_offset[81:18], file_size[145:82],
   // file_hash[209:146], status[212:210], file_count[244:213], zero pad[247:245]
   output logic [247:0]                      rsp_tdata,
   output logic [3:0]                        rsp_tuser,   // record_type[1:0], string_field[3:2]
   output logic                              rsp_tlast,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pip_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pip_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pip_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   pip_pkg::pip_cfg_type cfg;
   pip_pkg::pip_cmd_type front_cmd;
   pip_pkg::pip_cmd_type head_cmd;
   pip_pkg::pip_rsp_type out_rsp;
   logic                 front_push;
   logic                 queue_full;
   logic                 head_valid;
   logic                 pop;
   logic                 accept;

   assign csr_pready = 1'b1;

   // Take an item whenever the queue can hold whatever it may produce.
   assign req_tready = ~queue_full;
   assign accept     = req_tvalid & req_tready;

   pip_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   pip_front #(
      .MAX_FILES (MAX_FILES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .kind           (req_tuser),
      .data_byte      (req_tdata[7:0]),
      .package_length (req_tdata[71:8]),
      .cfg            (cfg),
      .push           (front_push),
      .cmd            (front_cmd)
   );

   pip_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_cmd   (front_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   pip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rsp    (out_rsp)
   );

   // Pack the result item onto the stream.
   assign rsp_tdata = {3'b000,
                       out_rsp.file_count,
                       out_rsp.status,
                       out_rsp.file_hash,
                       out_rsp.file_size,
                       out_rsp.file_offset,
                       out_rsp.entry_index,
                       out_rsp.char_value};
   assign rsp_tuser = {out_rsp.field, out_rsp.rec};
   assign rsp_tlast = out_rsp.last;

endmodule
`default_nettype wire
